// File: sv/dopbt_pkg.sv
// shared types, constants and helpers for the dram open page bank tracker
// no dependencies
`default_nettype none

package dopbt_pkg;

    localparam int COL_BITS     = 8;
    localparam int ROW_BITS     = 4;
    localparam int BANK_BITS    = 1;
    localparam int RANK_BITS    = 1;
    localparam int CHANNEL_BITS = 1;

    localparam int COL_LSB  = 0;
    localparam int ROW_LSB  = COL_LSB + COL_BITS;
    localparam int BANK_LSB = ROW_LSB + ROW_BITS;
    localparam int RANK_LSB = BANK_LSB + BANK_BITS;
    localparam int CH_LSB   = RANK_LSB + RANK_BITS;

    localparam int ADDR_BITS = CH_LSB + CHANNEL_BITS;
    localparam int SEL_BITS  = BANK_BITS + RANK_BITS + CHANNEL_BITS;
    localparam int NUM_BUFS  = 1 << SEL_BITS;
    localparam int LAT_BITS  = 10;
    localparam int CNT_BITS  = 32;

    localparam int S_TDATA_W = ((ADDR_BITS + 7) / 8) * 8;
    localparam int M_FIELD_W = ADDR_BITS + LAT_BITS + 4 * CNT_BITS;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LAT_BITS-1:0] HIT_LAT_RST  = 10'd50;
    localparam logic [LAT_BITS-1:0] MISS_LAT_RST = 10'd600;

    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef enum logic [0:0] {
        REG_HIT_LAT  = 1'b0,
        REG_MISS_LAT = 1'b1
    } t_reg_idx;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == '1) ? v : v + t_cnt'(1);
    endfunction

endpackage

`default_nettype wire

// File: sv/dram_open_page_bank_tracker_unit.sv
// Open-page row buffer tracker: classifies each request as page hit or miss per bank
// and keeps saturating hit, miss, read and write totals. One request is accepted per
// clock while the slave side is not back-pressured; its result is shown on the master side
// at the edge where it moves from the input register into the result register (two
// register stages, with the row buffer file and totals updated as the result register
// loads). A stalled master side holds the result and back-pressures the slave side only
// once both stages are full. Row buffers and totals clear at reset; latencies reset to
// 50 and 600.
// depends on dopbt_pkg
`default_nettype none

module dram_open_page_bank_tracker_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // config port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [dopbt_pkg::PADDR_W-1:0]     paddr,
    input  wire  [dopbt_pkg::PDATA_W-1:0]     pwdata,
    output logic [dopbt_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    // request stream
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // req_address, zero pad
    input  wire  [dopbt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // is_write
    input  wire                               s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // channel_index, rank_index, bank_index, row_index, column_index, access_latency,
    // hit_total, miss_total, read_total, write_total, zero pad
    output logic [dopbt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // page_hit
    output logic                              m_axis_tuser
);
    import dopbt_pkg::*;

    logic [LAT_BITS-1:0]  r_hit_lat, r_miss_lat;
    t_reg_idx             reg_idx;
    logic                 cfg_wr;

    logic                 r_s1_valid;
    logic [ADDR_BITS-1:0] r_s1_addr;
    logic                 r_s1_wr;

    logic [ROW_BITS-1:0]  r_open_row [NUM_BUFS];
    logic [NUM_BUFS-1:0]  r_row_vld;

    logic                 r_m_valid;
    logic [ADDR_BITS-1:0] r_m_addr;
    logic                 r_m_hit;
    logic [LAT_BITS-1:0]  r_m_lat;

    t_cnt r_hit_cnt, r_miss_cnt, r_rd_cnt, r_wr_cnt;
    t_cnt n_hit_cnt, n_miss_cnt, n_rd_cnt, n_wr_cnt;

    logic                 adv;
    logic [SEL_BITS-1:0]  sel;
    logic [ROW_BITS-1:0]  row;
    logic                 hit;

    // config registers
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_lat  <= HIT_LAT_RST;
            r_miss_lat <= MISS_LAT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_HIT_LAT:  r_hit_lat  <= pwdata[LAT_BITS-1:0];
                REG_MISS_LAT: r_miss_lat <= pwdata[LAT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HIT_LAT:  prdata = PDATA_W'(r_hit_lat);
            REG_MISS_LAT: prdata = PDATA_W'(r_miss_lat);
            default:      prdata = '0;
        endcase
    end

    // handshake
    assign adv           = !r_m_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_addr <= s_axis_tdata[ADDR_BITS-1:0];
            r_s1_wr   <= s_axis_tuser;
        end
    end

    // row buffer lookup
    assign sel = r_s1_addr[ADDR_BITS-1:BANK_LSB];
    assign row = r_s1_addr[ROW_LSB +: ROW_BITS];
    assign hit = r_row_vld[sel] && (r_open_row[sel] == row);

    always_comb begin
        n_hit_cnt  = hit ? sat_inc(r_hit_cnt) : r_hit_cnt;
        n_miss_cnt = hit ? r_miss_cnt : sat_inc(r_miss_cnt);
        n_rd_cnt   = r_s1_wr ? r_rd_cnt : sat_inc(r_rd_cnt);
        n_wr_cnt   = r_s1_wr ? sat_inc(r_wr_cnt) : r_wr_cnt;
    end

    // row buffer file, totals and valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld  <= '0;
            r_m_valid  <= 1'b0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_rd_cnt   <= '0;
            r_wr_cnt   <= '0;
        end else if (adv) begin
            r_m_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
                r_rd_cnt   <= n_rd_cnt;
                r_wr_cnt   <= n_wr_cnt;
                if (!hit) begin
                    r_row_vld[sel] <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_m_addr <= r_s1_addr;
            r_m_hit  <= hit;
            r_m_lat  <= hit ? r_hit_lat : r_miss_lat;
            if (!hit) begin
                r_open_row[sel] <= row;
            end
        end
    end

    // result
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_hit;
    assign m_axis_tdata  = {
        {M_PAD_W{1'b0}},
        r_wr_cnt, r_rd_cnt, r_miss_cnt, r_hit_cnt,
        r_m_lat,
        r_m_addr[COL_LSB +: COL_BITS],
        r_m_addr[ROW_LSB +: ROW_BITS],
        r_m_addr[BANK_LSB +: BANK_BITS],
        r_m_addr[RANK_LSB +: RANK_BITS],
        r_m_addr[CH_LSB +: CHANNEL_BITS]
    };

endmodule

`default_nettype wire

// File: sv/dopbt_chk.sv
// port-level checker for the dram open page bank tracker, bound to the top level
// depends on dopbt_pkg
`default_nettype none

module dopbt_chk (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               s_axis_tready,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire  [dopbt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire                               m_axis_tuser
);
    import dopbt_pkg::*;

    localparam int HIT_LSB  = ADDR_BITS + LAT_BITS;
    localparam int MISS_LSB = HIT_LSB + CNT_BITS;
    localparam int RD_LSB   = MISS_LSB + CNT_BITS;
    localparam int WR_LSB   = RD_LSB + CNT_BITS;

    logic        out_xfer;
    t_cnt        hit_tot, miss_tot, rd_tot, wr_tot;
    t_cnt        r_prev_hit, r_prev_miss;
    logic        any_sat;
    logic [CNT_BITS:0] sum_hm, sum_rw;

    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign hit_tot  = m_axis_tdata[HIT_LSB +: CNT_BITS];
    assign miss_tot = m_axis_tdata[MISS_LSB +: CNT_BITS];
    assign rd_tot   = m_axis_tdata[RD_LSB +: CNT_BITS];
    assign wr_tot   = m_axis_tdata[WR_LSB +: CNT_BITS];
    assign any_sat  = (hit_tot == '1) || (miss_tot == '1) || (rd_tot == '1) || (wr_tot == '1);
    assign sum_hm   = {1'b0, hit_tot} + {1'b0, miss_tot};
    assign sum_rw   = {1'b0, rd_tot} + {1'b0, wr_tot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_hit  <= '0;
            r_prev_miss <= '0;
        end else if (out_xfer) begin
            r_prev_hit  <= hit_tot;
            r_prev_miss <= miss_tot;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_hit_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> hit_tot == (m_axis_tuser ? sat_inc(r_prev_hit) : r_prev_hit))
        else $error("hit total does not follow page hit");

    a_miss_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> miss_tot == (m_axis_tuser ? r_prev_miss : sat_inc(r_prev_miss)))
        else $error("miss total does not follow page miss");

    a_tot_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !any_sat |-> sum_hm == sum_rw)
        else $error("hit plus miss differs from read plus write");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while result side can move");

endmodule

bind dram_open_page_bank_tracker_unit dopbt_chk u_dopbt_chk (.*);

`default_nettype wire

// File: test/tb_dram_open_page_bank_tracker_unit.sv
// testbench for dram_open_page_bank_tracker_unit: drives requests and register writes, predicts
// page hit/miss, latency and saturating totals per request and checks every result transaction
// depends on dopbt_pkg and dram_open_page_bank_tracker_unit
`timescale 1ns / 100ps

module tb_dram_open_page_bank_tracker_unit;

    import dopbt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          PHASE_COUNT = 10;
    localparam int          PHASE_ITEMS = 100;

    // channel is the lowest field
    typedef struct packed {
        logic [CNT_BITS-1:0] write_total;
        logic [CNT_BITS-1:0] read_total;
        logic [CNT_BITS-1:0] miss_total;
        logic [CNT_BITS-1:0] hit_total;
        logic [LAT_BITS-1:0] latency;
        logic [COL_BITS-1:0] column;
        logic [ROW_BITS-1:0] row;
        logic                bank;
        logic                rank;
        logic                channel;
    } t_page_fields;

    typedef struct packed {
        t_page_fields fields;
        logic         page_hit;
    } t_page_result;

    class page_hit_predictor;
        logic [ROW_BITS-1:0] open_row [NUM_BUFS];
        bit                  row_open [NUM_BUFS];
        t_cnt                hits, misses, reads, writes;
        logic [LAT_BITS-1:0] hit_lat, miss_lat;
        t_page_result        expected_results [$];
        int                  errors;

        function void clear();
            foreach (open_row[i]) begin
                open_row[i] = '0;
                row_open[i] = 1'b0;
            end
            hits     = '0;
            misses   = '0;
            reads    = '0;
            writes   = '0;
            hit_lat  = HIT_LAT_RST;
            miss_lat = MISS_LAT_RST;
            expected_results.delete();
            errors   = 0;
        endfunction

        function void set_latency(t_reg_idx idx, logic [PDATA_W-1:0] value);
            if (idx == REG_HIT_LAT)
                hit_lat = value[LAT_BITS-1:0];
            else
                miss_lat = value[LAT_BITS-1:0];
        endfunction

        function void note_request(logic [ADDR_BITS-1:0] addr, logic wr);
            t_page_result        r;
            logic [SEL_BITS-1:0] buf_sel;
            r.fields.column  = addr[COL_LSB +: COL_BITS];
            r.fields.row     = addr[ROW_LSB +: ROW_BITS];
            r.fields.bank    = addr[BANK_LSB];
            r.fields.rank    = addr[RANK_LSB];
            r.fields.channel = addr[CH_LSB];
            buf_sel = {r.fields.channel, r.fields.rank, r.fields.bank};
            if (wr) begin
                if (writes != '1) writes++;
            end else begin
                if (reads != '1) reads++;
            end
            r.page_hit = row_open[buf_sel] && (open_row[buf_sel] == r.fields.row);
            if (r.page_hit) begin
                if (hits != '1) hits++;
                r.fields.latency = hit_lat;
            end else begin
                if (misses != '1) misses++;
                open_row[buf_sel] = r.fields.row;
                row_open[buf_sel] = 1'b1;
                r.fields.latency  = miss_lat;
            end
            r.fields.hit_total   = hits;
            r.fields.miss_total  = misses;
            r.fields.read_total  = reads;
            r.fields.write_total = writes;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void compare_field(string name, logic [CNT_BITS-1:0] want,
                                    logic [CNT_BITS-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic hit);
            t_page_result want;
            t_page_fields got;
            if (expected_results.size() == 0) begin
                $display("%0t: result transaction with nothing expected, actual %0h",
                         $time, data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            got  = t_page_fields'(data[M_FIELD_W-1:0]);
            compare_field("channel_index", t_cnt'(want.fields.channel), t_cnt'(got.channel));
            compare_field("rank_index", t_cnt'(want.fields.rank), t_cnt'(got.rank));
            compare_field("bank_index", t_cnt'(want.fields.bank), t_cnt'(got.bank));
            compare_field("row_index", t_cnt'(want.fields.row), t_cnt'(got.row));
            compare_field("column_index", t_cnt'(want.fields.column), t_cnt'(got.column));
            compare_field("page_hit", t_cnt'(want.page_hit), t_cnt'(hit));
            compare_field("access_latency", t_cnt'(want.fields.latency), t_cnt'(got.latency));
            compare_field("hit_total", want.fields.hit_total, got.hit_total);
            compare_field("miss_total", want.fields.miss_total, got.miss_total);
            compare_field("read_total", want.fields.read_total, got.read_total);
            compare_field("write_total", want.fields.write_total, got.write_total);
            compare_field("tdata pad", '0, CNT_BITS'(data[M_TDATA_W-1:M_FIELD_W]));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;    // req_address, zero pad
    logic                 s_axis_tuser = 1'b0;  // is_write
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // channel_index, rank_index, bank_index, row_index, column_index, access_latency,
    // hit_total, miss_total, read_total, write_total, zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;         // page_hit

    page_hit_predictor    tracker_model;
    bit                   tx_idle_on = 1'b0;
    bit                   rx_idle_on = 1'b0;
    bit                   hold_off_req = 1'b0;
    int unsigned          cycle_count = 0;

    dram_open_page_bank_tracker_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // both handshakes observed at the same edge, request first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker_model.note_request(s_axis_tdata[ADDR_BITS-1:0], s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                tracker_model.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_dram_open_page_bank_tracker_unit: done, errors");
            $finish;
        end
    end

    // result side ready pattern
    initial begin
        forever begin
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_request(logic [ADDR_BITS-1:0] addr, logic wr);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(addr);
        s_axis_tuser  <= wr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tracker_model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_latency(t_reg_idx idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker_model.set_latency(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [PDATA_W-1:0] pick_latency();
        logic [LAT_BITS-1:0] lat;
        case ($urandom_range(0, 3))
            0:       lat = '0;
            1:       lat = '1;
            default: lat = LAT_BITS'($urandom);
        endcase
        // upper bits are junk that the block must drop
        return ($urandom & ~PDATA_W'(10'h3FF)) | PDATA_W'(lat);
    endfunction

    initial begin
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] last_addr;
        tracker_model = new();
        tracker_model.clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first touches, hits, column and row extremes, every buffer
        send_request(15'h0000, 1'b0);
        send_request(15'h0000, 1'b1);
        send_request(15'h00FF, 1'b0);
        send_request(15'h0F00, 1'b1);
        send_request(15'h0F00, 1'b0);
        send_request(15'h0000, 1'b0);
        send_request(15'h1000, 1'b1);
        send_request(15'h2000, 1'b0);
        send_request(15'h3000, 1'b0);
        send_request(15'h4000, 1'b1);
        send_request(15'h5000, 1'b0);
        send_request(15'h6000, 1'b1);
        send_request(15'h7FFF, 1'b1);
        send_request(15'h7F00, 1'b0);
        send_request(15'h3000, 1'b1);
        send_request(15'h2500, 1'b0);
        drain_results();
        write_latency(REG_HIT_LAT, 32'd0);
        write_latency(REG_MISS_LAT, 32'd1023);
        send_request(15'h2500, 1'b1);
        send_request(15'h2600, 1'b0);
        drain_results();
        write_latency(REG_HIT_LAT, 32'hFFFF_FFFF);
        write_latency(REG_MISS_LAT, 32'hFFFF_FC00);
        send_request(15'h2600, 1'b1);
        send_request(15'h2700, 1'b0);
        drain_results();

        last_addr = 15'h2700;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            write_latency(REG_HIT_LAT, pick_latency());
            write_latency(REG_MISS_LAT, pick_latency());
            tx_idle_on = (phase % 2) == 1;
            rx_idle_on = (phase % 3) != 0;
            if (phase == 4) begin
                // fill the pipeline against a stalled result side
                tx_idle_on   = 1'b0;
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 1) == 1)
                    addr = {last_addr[ADDR_BITS-1:COL_BITS], COL_BITS'($urandom)};
                else
                    addr = ADDR_BITS'($urandom);
                send_request(addr, 1'($urandom));
                last_addr = addr;
            end
            drain_results();
        end

        drain_results();
        if (tracker_model.errors == 0 && tracker_model.pending() == 0)
            $display("tb_dram_open_page_bank_tracker_unit: done, clean");
        else
            $display("tb_dram_open_page_bank_tracker_unit: done, errors");
        $finish;
    end

endmodule
